// File: design/grbf_pkg.sv
package grbf_pkg;

  // Element width; the payload struct below is sized by it.
  localparam int ELEM_WIDTH = 16;
  localparam int SCALE_WIDTH = 24;
  localparam int KV_WIDTH = 16;

  localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 24'd65536;

  // log2(e) and ln(2) in Q1.30 / Q0.30.
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Exponent argument limit: 16.0 in Q.32.
  localparam logic [36:0] T_LIMIT = 37'h10_0000_0000;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] x_elem;
    logic signed [ELEM_WIDTH-1:0] y_elem;
    logic                         last_elem;
  } in_t;

  typedef struct packed {
    logic [KV_WIDTH-1:0] kernel_value;
    logic                sum_saturated;
  } out_t;

  // Datapath step enables issued by the controller.
  typedef struct packed {
    logic load_in;
    logic square;
    logic accum;
    logic scale;
    logic log2;
    logic frac;
    logic poly;
    logic mant;
    logic norm;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

  // Integer square root (floor), evaluated at elaboration only.
  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned res;
    longint unsigned bit_q;
    longint unsigned rem;
    int unsigned i;
    res = 0;
    bit_q = 64'd1 << 62;
    rem = v;
    for (i = 0; i < 32; i++) begin
      if (rem >= res + bit_q) begin
        rem = rem - (res + bit_q);
        res = (res >> 1) + bit_q;
      end else begin
        res = res >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return res;
  endfunction

  // Entry k of the 2^(-k/2^bits) table in Q1.30, built by repeated
  // multiplication with the 2^bits-th root of one half.
  function automatic longint unsigned pow2_entry(int unsigned bits, int unsigned k);
    longint unsigned r;
    longint unsigned e;
    int unsigned i;
    r = 64'h2000_0000;
    for (i = 0; i < bits; i++) begin
      r = isqrt64(r << 30);
    end
    e = 64'h4000_0000;
    for (i = 0; i < k; i++) begin
      e = (e * r + (64'd1 << 29)) >> 30;
    end
    return e;
  endfunction

endpackage

// File: design/gaussian_rbf_kernel_top.sv
// Gaussian RBF kernel over two streamed vectors.
// The input channel (in_valid, in_ready, in_data) carries one element pair per
// transfer; last_elem marks the final pair. Each pair adds its squared
// difference to a saturating running sum. The pair marked last produces one
// transfer on the output channel (out_valid, out_ready, out_data) carrying
// exp(-sum * scale) in Q0.16 and the saturation flag, then the sum clears.
// The config channel (cfg_valid, cfg_ready, cfg_data) writes the scale,
// 1/(2*sigma^2) in Q8.16; cfg_ready is always high. Write it only while idle.
// Each pair is registered, squared and accumulated in one controller step
// each. A last pair then runs six more steps of the exponential datapath;
// its result shows on out_valid after the final step, and the next pair can
// be taken in the same cycle that out_valid rises. A pending result sits in
// the output register while new pairs are accepted; if the receiver stalls,
// the next result waits in the final step until the output register is
// free. Reset clears the sum, the flag and the control state, and sets the
// scale to 1.0.
module gaussian_rbf_kernel_top #(
  parameter int SUM_WIDTH = 48,
  parameter int EXP_TABLE_BITS = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  grbf_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output grbf_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [grbf_pkg::SCALE_WIDTH-1:0]  cfg_data
);

  grbf_pkg::cmd_t  cmd;
  grbf_pkg::stat_t stat;

  // The scale register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  grbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  grbf_dpath #(
    .SUM_WIDTH      (SUM_WIDTH),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // A pair is never taken twice: the block is busy right after a transfer.
  a_no_double_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in consecutive cycles");

  // Loading the result register always raises out_valid.
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.norm |=> out_valid)
    else $error("result loaded without out_valid");

  // The exponential starts only from a just-finished accumulation.
  a_scale_after_acc: assert property (@(posedge clk) disable iff (rst)
    cmd.scale |-> $past(cmd.accum))
    else $error("kernel started without a preceding accumulate");

endmodule

// File: design/grbf_ctrl.sv
module grbf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  grbf_pkg::stat_t    stat,
  output grbf_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_SCALE = 4'd3;
  localparam logic [3:0] S_LOG   = 4'd4;
  localparam logic [3:0] S_FRAC  = 4'd5;
  localparam logic [3:0] S_POLY  = 4'd6;
  localparam logic [3:0] S_MANT  = 4'd7;
  localparam logic [3:0] S_NORM  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_next = stat.last ? S_SCALE : S_IDLE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_next = S_LOG;
      end
      S_LOG: begin
        cmd.log2 = 1'b1;
        state_next = S_FRAC;
      end
      S_FRAC: begin
        cmd.frac = 1'b1;
        state_next = S_POLY;
      end
      S_POLY: begin
        cmd.poly = 1'b1;
        state_next = S_MANT;
      end
      S_MANT: begin
        cmd.mant = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        // The result register frees up in the same cycle it is taken.
        if (!out_valid || out_ready) begin
          cmd.norm = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.norm) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/grbf_dpath.sv
module grbf_dpath #(
  parameter int SUM_WIDTH = 48,
  parameter int EXP_TABLE_BITS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  grbf_pkg::in_t                      in_data,
  input  logic                               cfg_valid,
  input  logic [grbf_pkg::SCALE_WIDTH-1:0]   cfg_data,
  input  grbf_pkg::cmd_t                     cmd,
  output grbf_pkg::stat_t                    stat,
  output grbf_pkg::out_t                     out_data
);

  localparam int EW = grbf_pkg::ELEM_WIDTH;
  localparam int DW = EW + 1;
  localparam int SQ_W = 2 * DW;
  localparam int ACC_W = ((SUM_WIDTH > SQ_W) ? SUM_WIDTH : SQ_W) + 1;
  localparam int TAB_SIZE = 1 << EXP_TABLE_BITS;
  localparam int RW = 16 - EXP_TABLE_BITS;
  localparam int AP_W = RW + 30;
  localparam int AW = RW + 14;
  localparam int ASQ_W = 2 * AW;

  // Input and accumulation registers.
  logic signed [EW-1:0]      x_q;
  logic signed [EW-1:0]      y_q;
  logic                      last_q;
  logic [SQ_W-1:0]           sq_q;
  logic [SUM_WIDTH-1:0]      sum_q;
  logic                      ovf_q;
  logic [grbf_pkg::SCALE_WIDTH-1:0] scale_q;

  // Exponential pipeline registers, each loaded by one step.
  logic                      kflag_q;
  logic [36:0]               t_q;
  logic [21:0]               u16_q;
  logic [AW-1:0]             a_q;
  logic [30:0]               tab_q;
  logic [5:0]                n_q;
  logic [30:0]               factor_q;
  logic [31:0]               mant_q;
  grbf_pkg::out_t            out_q;

  logic [30:0] pow2_rom [TAB_SIZE];

  for (genvar k = 0; k < TAB_SIZE; k++) begin : g_rom
    assign pow2_rom[k] = 31'(grbf_pkg::pow2_entry(EXP_TABLE_BITS, k));
  end

  // Squared difference.
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        mag;
  logic [SQ_W-1:0]      sq_next;

  assign diff = DW'(x_q) - DW'(y_q);
  assign mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign sq_next = SQ_W'(mag) * SQ_W'(mag);

  // Saturating accumulate.
  logic [ACC_W-1:0] sum_wide;
  logic             sum_over;

  assign sum_wide = ACC_W'(sum_q) + ACC_W'(sq_q);
  assign sum_over = sum_wide > ACC_W'({SUM_WIDTH{1'b1}});

  // Scaling by the configured inverse variance, clamped to 16.0.
  logic [55:0] scale_prod;
  logic        hi_nz;
  logic [36:0] t_next;

  assign scale_prod = 56'(sum_q[31:0]) * 56'(scale_q);
  assign hi_nz = (sum_q >> 32) != '0;
  assign t_next = ((hi_nz && (scale_q != '0)) || (scale_prod > 56'(grbf_pkg::T_LIMIT))) ?
                  grbf_pkg::T_LIMIT : 37'(scale_prod);

  // Conversion to base 2, rounded to Q.16.
  logic [55:0] log_prod;
  logic [55:0] log_round;

  assign log_prod = 56'(t_q[36:12]) * 56'(grbf_pkg::LOG2E_Q30);
  assign log_round = log_prod + (56'd1 << 33);

  // Fraction split: table index and polynomial remainder.
  logic [EXP_TABLE_BITS-1:0] idx;
  logic [RW-1:0]             rem;
  logic [AP_W-1:0]           a_prod;

  assign idx = u16_q[15 -: EXP_TABLE_BITS];
  assign rem = u16_q[RW-1:0];
  assign a_prod = AP_W'(rem) * AP_W'(grbf_pkg::LN2_Q30);

  // Second order correction factor 1 - a + a^2/2.
  logic [ASQ_W-1:0] a_sq;
  logic [31:0]      factor_sum;

  assign a_sq = ASQ_W'(a_q) * ASQ_W'(a_q);
  assign factor_sum = 32'(grbf_pkg::ONE_Q30) - 32'(a_q) + 32'(a_sq >> 31);

  logic [61:0] m_prod;

  assign m_prod = 62'(tab_q) * 62'(factor_q) + (62'd1 << 29);

  // Normalization by the integer part of the exponent.
  logic [6:0]  shamt;
  logic [63:0] norm_round;
  logic [63:0] norm_val;
  logic [15:0] kv_next;

  assign shamt = 7'd14 + 7'(n_q);
  assign norm_round = 64'(mant_q) + (64'd1 << (shamt - 7'd1));
  assign norm_val = norm_round >> shamt;

  always_comb begin
    if (shamt >= 7'd62) begin
      kv_next = '0;
    end else if (norm_val > 64'd65535) begin
      kv_next = 16'hFFFF;
    end else begin
      kv_next = norm_val[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_q <= '0;
      ovf_q <= 1'b0;
      scale_q <= grbf_pkg::SCALE_RESET;
    end else begin
      if (cfg_valid) begin
        scale_q <= cfg_data;
      end
      if (cmd.accum) begin
        if (sum_over) begin
          sum_q <= '1;
          ovf_q <= 1'b1;
        end else begin
          sum_q <= sum_wide[SUM_WIDTH-1:0];
        end
      end else if (cmd.scale) begin
        sum_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_q <= in_data.x_elem;
      y_q <= in_data.y_elem;
      last_q <= in_data.last_elem;
    end
    if (cmd.square) begin
      sq_q <= sq_next;
    end
    if (cmd.scale) begin
      t_q <= t_next;
      kflag_q <= ovf_q;
    end
    if (cmd.log2) begin
      u16_q <= log_round[55:34];
    end
    if (cmd.frac) begin
      a_q <= a_prod[AP_W-1:16];
      tab_q <= pow2_rom[idx];
      n_q <= u16_q[21:16];
    end
    if (cmd.poly) begin
      factor_q <= factor_sum[30:0];
    end
    if (cmd.mant) begin
      mant_q <= m_prod[61:30];
    end
    if (cmd.norm) begin
      out_q.kernel_value <= kv_next;
      out_q.sum_saturated <= kflag_q;
    end
  end

  assign stat.last = last_q;
  assign out_data = out_q;

endmodule
